// ===== design/btm_pkg.sv =====
// Package for the bracket tape machine: command codes, result kinds, modes.
// No dependencies; used by every module of the design.
package btm_pkg;

  localparam int unsigned ProgDepthDef = 1024;
  localparam int unsigned TapeDepthDef = 1024;
  localparam int unsigned NestDepthDef = 64;

  localparam int unsigned KindW = 4;
  localparam int unsigned PcW   = 11;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_FEED  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_WAIT = 2'd2,
    MODE_HALT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    C_RIGHT = 3'd0,
    C_LEFT  = 3'd1,
    C_INC   = 3'd2,
    C_DEC   = 3'd3,
    C_OUT   = 3'd4,
    C_IN    = 3'd5,
    C_OPEN  = 3'd6,
    C_CLOSE = 3'd7
  } cmd_t;

  localparam logic [KindW-1:0] K_OUT      = 4'd0;
  localparam logic [KindW-1:0] K_NEED     = 4'd1;
  localparam logic [KindW-1:0] K_HALT     = 4'd2;
  localparam logic [KindW-1:0] K_LIMIT    = 4'd3;
  localparam logic [KindW-1:0] K_MISMATCH = 4'd4;
  localparam logic [KindW-1:0] K_UNDER    = 4'd5;
  localparam logic [KindW-1:0] K_OVER     = 4'd6;
  localparam logic [KindW-1:0] K_FULL     = 4'd7;
  localparam logic [KindW-1:0] K_ACCEPT   = 4'd8;
  localparam logic [KindW-1:0] K_IGNORE   = 4'd9;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_FETCH,
    S_EXEC,
    S_WRITE,
    S_PAIR
  } seq_t;

  // Source character to command; valid flag in bit 3
  function automatic logic [3:0] decode_char(input logic [7:0] ch);
    logic [3:0] r;
    case (ch)
      8'h3E:   r = {1'b1, C_RIGHT};
      8'h3C:   r = {1'b1, C_LEFT};
      8'h2B:   r = {1'b1, C_INC};
      8'h2D:   r = {1'b1, C_DEC};
      8'h2E:   r = {1'b1, C_OUT};
      8'h2C:   r = {1'b1, C_IN};
      8'h5B:   r = {1'b1, C_OPEN};
      8'h5D:   r = {1'b1, C_CLOSE};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/btm_tape.sv =====
// Tape memory with one write port and a registered read port.
// Depends on btm_pkg.
module btm_tape #(
  parameter int unsigned TAPE_DEPTH = btm_pkg::TapeDepthDef
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(TAPE_DEPTH)-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic [$clog2(TAPE_DEPTH)-1:0] raddr,
  output logic [7:0]                    rdata
);
  import btm_pkg::*;

  logic [7:0] mem [TAPE_DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/btm_prog.sv =====
// Program store and jump table: one write and one registered read each.
// Depends on btm_pkg.
module btm_prog #(
  parameter int unsigned PROG_DEPTH = btm_pkg::ProgDepthDef
) (
  input  logic                          clk,
  input  logic                          cmd_we,
  input  logic [$clog2(PROG_DEPTH)-1:0] cmd_waddr,
  input  logic [2:0]                    cmd_wdata,
  input  logic                          jmp_we,
  input  logic [$clog2(PROG_DEPTH)-1:0] jmp_waddr,
  input  logic [$clog2(PROG_DEPTH)-1:0] jmp_wdata,
  input  logic [$clog2(PROG_DEPTH)-1:0] raddr,
  output logic [2:0]                    cmd_rdata,
  output logic [$clog2(PROG_DEPTH)-1:0] jmp_rdata
);
  import btm_pkg::*;

  localparam int unsigned AW = $clog2(PROG_DEPTH);

  logic [2:0]    cmem [PROG_DEPTH];
  logic [AW-1:0] jmem [PROG_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd_we) begin
      cmem[cmd_waddr] <= cmd_wdata;
    end
    cmd_rdata <= cmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (jmp_we) begin
      jmem[jmp_waddr] <= jmp_wdata;
    end
    jmp_rdata <= jmem[raddr];
  end

endmodule

// ===== design/bracket_tape_machine_core.sv =====
// Top level of the bracket tape machine: sequencer, stack, registers.
// Depends on btm_pkg, btm_prog, btm_tape.
//
// channel | ports                              | handshake
// input   | in_op, in_payload                  | start & !busy
// result  | out_kind, out_out_byte, out_at_pc  | out_strobe, one cycle
// config  | cfg_step_limit                     | cfg_valid & cfg_ready
//
// Load, feed and refused items: result in the next cycle; a ']' load keeps
// busy high through S_WRITE and S_PAIR to pair the brackets. Clear: an
// S_CLEAR sweep zeroes every tape cell. Run: accept, then S_FETCH (program
// read) and S_EXEC (execute, write back) per instruction; a halt or
// step-limit stop ends in S_FETCH. After reset a clearing pass zeroes the
// tape, busy high meanwhile. Results cannot be stalled; cfg is ready when idle.
module bracket_tape_machine_core #(
  parameter int unsigned PROG_DEPTH = btm_pkg::ProgDepthDef,
  parameter int unsigned TAPE_DEPTH = btm_pkg::TapeDepthDef,
  parameter int unsigned NEST_DEPTH = btm_pkg::NestDepthDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_op,
  input  logic [7:0]              in_payload,
  output logic                    out_strobe,
  output logic [btm_pkg::KindW-1:0] out_kind,
  output logic [7:0]              out_out_byte,
  output logic [btm_pkg::PcW-1:0] out_at_pc,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [15:0]             cfg_step_limit
);
  import btm_pkg::*;

  localparam int unsigned PAW = $clog2(PROG_DEPTH);
  localparam int unsigned LW  = $clog2(PROG_DEPTH + 1);
  localparam int unsigned TAW = $clog2(TAPE_DEPTH);
  localparam int unsigned NAW = $clog2(NEST_DEPTH);
  localparam int unsigned NW  = $clog2(NEST_DEPTH + 1);
  localparam logic [LW-1:0]  ProgDepthL = LW'(PROG_DEPTH);
  localparam logic [TAW-1:0] TapeLast   = TAW'(TAPE_DEPTH - 1);
  localparam logic [NW-1:0]  NestDepthL = NW'(NEST_DEPTH);

  seq_t            st_r, st_nxt;
  mode_t           mode_r, mode_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   pc_r, pc_nxt;
  logic [TAW-1:0]  dp_r, dp_nxt;
  logic [NW-1:0]   nest_r, nest_nxt;
  logic [15:0]     limit_r;
  logic [15:0]     steps_r, steps_nxt;
  logic [TAW-1:0]  clr_r, clr_nxt;
  logic [PAW-1:0]  stk [NEST_DEPTH];
  logic [NAW-1:0]  stk_top;
  logic [PAW-1:0]  stk_q;
  logic            stk_we;
  logic            clr_pend_r;

  // result holding register
  logic            res_v_r, res_v_nxt;
  logic [KindW-1:0] res_k_r, res_k_nxt;
  logic [7:0]      res_b_r, res_b_nxt;
  logic [PcW-1:0]  res_pc_r, res_pc_nxt;

  logic            cmd_we, jmp_we, tape_we;
  logic [PAW-1:0]  cmd_waddr, jmp_waddr, jmp_wdata, prd_addr;
  logic [2:0]      cmd_wdata, cmd_q;
  logic [PAW-1:0]  jmp_q;
  logic [TAW-1:0]  t_waddr, t_raddr;
  logic [7:0]      t_wdata, t_q;
  logic [3:0]      dec;
  logic [PAW-1:0]  at_a;
  logic            accept;

  assign busy      = (st_r != S_IDLE);
  assign cfg_ready = (st_r == S_IDLE);
  assign accept    = start && !busy;
  assign out_strobe   = res_v_r;
  assign out_kind     = res_k_r;
  assign out_out_byte = res_b_r;
  assign out_at_pc    = res_pc_r;

  assign dec     = decode_char(in_payload);
  assign at_a    = len_r[PAW-1:0];
  assign stk_top = NAW'(nest_r - NW'(1));

  btm_prog #(.PROG_DEPTH(PROG_DEPTH)) u_prog (
    .clk(clk), .cmd_we(cmd_we), .cmd_waddr(cmd_waddr), .cmd_wdata(cmd_wdata),
    .jmp_we(jmp_we), .jmp_waddr(jmp_waddr), .jmp_wdata(jmp_wdata),
    .raddr(prd_addr), .cmd_rdata(cmd_q), .jmp_rdata(jmp_q)
  );

  btm_tape #(.TAPE_DEPTH(TAPE_DEPTH)) u_tape (
    .clk(clk), .we(tape_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_q)
  );

  // open bracket stack; top is read into a register while idle and held
  // through the pairing writes
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[nest_r[NAW-1:0]] <= at_a;
    end
    if (st_r == S_IDLE) begin
      stk_q <= stk[stk_top];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      mode_r  <= MODE_LOAD;
      len_r   <= '0;
      pc_r    <= '0;
      dp_r    <= '0;
      nest_r  <= '0;
      limit_r <= 16'hFFFF;
      steps_r <= '0;
      clr_r   <= '0;
      res_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      pc_r    <= pc_nxt;
      dp_r    <= dp_nxt;
      nest_r  <= nest_nxt;
      steps_r <= steps_nxt;
      clr_r   <= clr_nxt;
      res_v_r <= res_v_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_step_limit;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_k_r  <= res_k_nxt;
    res_b_r  <= res_b_nxt;
    res_pc_r <= res_pc_nxt;
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;  mode_nxt = mode_r;  len_nxt = len_r;  pc_nxt = pc_r;
    dp_nxt = dp_r;  nest_nxt = nest_r;  steps_nxt = steps_r;  clr_nxt = clr_r;
    res_v_nxt = 1'b0;  res_k_nxt = res_k_r;  res_b_nxt = 8'd0;
    res_pc_nxt = res_pc_r;
    cmd_we = 1'b0;  cmd_waddr = at_a;  cmd_wdata = dec[2:0];
    jmp_we = 1'b0;  jmp_waddr = at_a;  jmp_wdata = stk_q;
    stk_we = 1'b0;
    tape_we = 1'b0;  t_waddr = dp_r;  t_wdata = t_q;  t_raddr = dp_r;
    prd_addr = pc_r[PAW-1:0];
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          res_v_nxt = 1'b1;
          res_b_nxt = 8'd0;
          case (op_t'(in_op))
            OP_LOAD: begin
              res_pc_nxt = PcW'(len_r);
              if (mode_r != MODE_LOAD || !dec[3]) begin
                res_k_nxt = K_IGNORE;
              end else if (len_r >= ProgDepthL) begin
                res_k_nxt = K_FULL;
              end else if (dec[2:0] == C_OPEN && nest_r >= NestDepthL) begin
                res_k_nxt = K_MISMATCH;  mode_nxt = MODE_HALT;
              end else if (dec[2:0] == C_CLOSE && nest_r == '0) begin
                res_k_nxt = K_MISMATCH;  mode_nxt = MODE_HALT;
              end else begin
                res_k_nxt = K_ACCEPT;
                cmd_we = 1'b1;
                len_nxt = len_r + LW'(1);
                if (dec[2:0] == C_OPEN) begin
                  stk_we = 1'b1;  nest_nxt = nest_r + NW'(1);
                end else if (dec[2:0] == C_CLOSE) begin
                  // both jump entries are written once the stack top is read
                  nest_nxt = nest_r - NW'(1);
                  st_nxt = S_WRITE;
                end
              end
            end
            OP_RUN: begin
              res_pc_nxt = PcW'(pc_r);
              if (mode_r == MODE_LOAD && nest_r != '0) begin
                res_k_nxt = K_MISMATCH;  res_pc_nxt = '0;  mode_nxt = MODE_HALT;
              end else if (mode_r == MODE_WAIT) begin
                res_k_nxt = K_NEED;
              end else if (mode_r == MODE_HALT) begin
                res_k_nxt = K_HALT;
              end else begin
                res_v_nxt = 1'b0;  mode_nxt = MODE_RUN;
                steps_nxt = '0;  st_nxt = S_FETCH;
              end
            end
            OP_FEED: begin
              res_pc_nxt = PcW'(pc_r);
              if (mode_r != MODE_WAIT) begin
                res_k_nxt = K_IGNORE;
              end else begin
                res_k_nxt = K_ACCEPT;  tape_we = 1'b1;
                t_wdata = in_payload;  mode_nxt = MODE_RUN;
              end
            end
            default: begin
              res_k_nxt = K_ACCEPT;  res_pc_nxt = '0;  res_v_nxt = 1'b0;
              mode_nxt = MODE_LOAD;  len_nxt = '0;  pc_nxt = '0;
              dp_nxt = '0;  nest_nxt = '0;  clr_nxt = '0;  st_nxt = S_CLEAR;
            end
          endcase
        end
      end
      S_WRITE: begin
        // close entry (at len-1) points at its open bracket
        jmp_we = 1'b1;
        jmp_waddr = PAW'(len_r - LW'(1));
        jmp_wdata = stk_q;
        st_nxt = S_PAIR;
      end
      S_PAIR: begin
        // open entry points at the close just stored
        jmp_we = 1'b1;
        jmp_waddr = stk_q;
        jmp_wdata = PAW'(len_r - LW'(1));
        st_nxt = S_IDLE;
      end
      S_CLEAR: begin
        tape_we = 1'b1;  t_waddr = clr_r;  t_wdata = 8'd0;
        clr_nxt = clr_r + TAW'(1);
        if (clr_r == TapeLast) begin
          st_nxt = S_IDLE;  clr_nxt = '0;
        end
      end
      S_FETCH: begin
        if (pc_r >= len_r) begin
          mode_nxt = MODE_HALT;  res_v_nxt = 1'b1;  res_k_nxt = K_HALT;
          res_pc_nxt = PcW'(pc_r);  st_nxt = S_IDLE;
        end else if (steps_r >= limit_r) begin
          res_v_nxt = 1'b1;  res_k_nxt = K_LIMIT;
          res_pc_nxt = PcW'(pc_r);  st_nxt = S_IDLE;
        end else begin
          steps_nxt = steps_r + 16'd1;  st_nxt = S_EXEC;
        end
      end
      default: begin
        // S_EXEC: command, jump target and cell are now registered
        pc_nxt = pc_r + LW'(1);
        st_nxt = S_FETCH;
        res_pc_nxt = PcW'(pc_r);
        case (cmd_t'(cmd_q))
          C_RIGHT: begin
            if (dp_r == TapeLast) begin
              mode_nxt = MODE_HALT;  pc_nxt = pc_r;  res_v_nxt = 1'b1;
              res_k_nxt = K_OVER;  st_nxt = S_IDLE;
            end else begin
              dp_nxt = dp_r + TAW'(1);
            end
          end
          C_LEFT: begin
            if (dp_r == '0) begin
              mode_nxt = MODE_HALT;  pc_nxt = pc_r;  res_v_nxt = 1'b1;
              res_k_nxt = K_UNDER;  st_nxt = S_IDLE;
            end else begin
              dp_nxt = dp_r - TAW'(1);
            end
          end
          C_INC: begin
            tape_we = 1'b1;  t_wdata = t_q + 8'd1;
          end
          C_DEC: begin
            tape_we = 1'b1;  t_wdata = t_q - 8'd1;
          end
          C_OUT: begin
            res_v_nxt = 1'b1;  res_k_nxt = K_OUT;  res_b_nxt = t_q;
            st_nxt = S_IDLE;
          end
          C_IN: begin
            mode_nxt = MODE_WAIT;  res_v_nxt = 1'b1;  res_k_nxt = K_NEED;
            st_nxt = S_IDLE;
          end
          C_OPEN: begin
            if (t_q == 8'd0) begin
              pc_nxt = LW'(jmp_q) + LW'(1);
            end
          end
          default: begin
            if (t_q != 8'd0) begin
              pc_nxt = LW'(jmp_q) + LW'(1);
            end
          end
        endcase
      end
    endcase
    // clear reports accepted at the end of its sweep
    if (st_r == S_CLEAR && clr_r == TapeLast) begin
      res_v_nxt = clr_pend_r;
      res_k_nxt = K_ACCEPT;
      res_pc_nxt = '0;
    end
  end

  // a clear item (not the power-up sweep) owes a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_pend_r <= 1'b0;
    end else if (accept && op_t'(in_op) == OP_CLEAR) begin
      clr_pend_r <= 1'b1;
    end else if (st_r == S_CLEAR && clr_r == TapeLast) begin
      clr_pend_r <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // a result leaves only when work ends or while a bracket pair is written
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (st_r == S_IDLE || st_r == S_WRITE))
    else $error("result while busy");
  // each accepted load or feed answers in the next cycle
  a_load_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_LOAD || in_op == OP_FEED)) |=> out_strobe)
    else $error("load without result");
  // nesting never exceeds the stack
  a_nest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nest_r <= NestDepthL) else $error("stack overrun");
  // program counter never passes the program end while executing
  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EXEC) |-> (pc_r < len_r)) else $error("pc past end");
`endif

endmodule

// ===== tb/sv/tb_bracket_tape_machine_core.sv =====
// Self-checking testbench for bracket_tape_machine_core: directed table, then
// random program sessions checked against an in-bench predictor of the machine.
// Depends on btm_pkg and the design sources only.
`timescale 1ns / 100ps

module tb_bracket_tape_machine_core;
  import btm_pkg::*;

  localparam int ProgDepth  = 1024;
  localparam int TapeDepth  = 1024;
  localparam int NestDepth  = 64;
  localparam int Watchdog   = 300000;
  localparam int TargetBeats = 1750;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  value;
    logic [10:0] pc;
  } result_t;

  typedef struct {
    op_t        op;
    logic [7:0] payload;
    bit         typed;
    result_t    res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [7:0]  in_payload;
  logic        out_strobe;
  logic [3:0]  out_kind;
  logic [7:0]  out_out_byte;
  logic [10:0] out_at_pc;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_step_limit;

  // Predictor state
  cmd_t       prog_mem [ProgDepth];
  int         jump_to  [ProgDepth];
  int         open_stk [NestDepth];
  logic [7:0] cells    [TapeDepth];
  int         depth;
  int         prog_len;
  int         ptr;
  int         pc_now;
  mode_t      mode;
  int         limit_now;

  result_t    pending_q[$];
  int         beats_done;
  int         mismatches;
  int         idle_cycles;
  bit         no_idle;

  bracket_tape_machine_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_payload(in_payload),
    .out_strobe(out_strobe), .out_kind(out_kind), .out_out_byte(out_out_byte),
    .out_at_pc(out_at_pc),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_step_limit(cfg_step_limit)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic result_t mk(logic [3:0] k, logic [7:0] v, int p);
    result_t r;
    r.kind = k;
    r.value = v;
    r.pc = p[10:0];
    return r;
  endfunction

  function automatic void wipe_machine();
    for (int i = 0; i < TapeDepth; i++) cells[i] = 8'd0;
    depth = 0;
    prog_len = 0;
    ptr = 0;
    pc_now = 0;
    mode = MODE_LOAD;
  endfunction

  // Execute until the next stop point, as the machine does for one run beat
  function automatic result_t execute_run();
    int steps;
    int p;
    steps = 0;
    if (mode == MODE_LOAD) begin
      if (depth != 0) begin
        mode = MODE_HALT;
        return mk(K_MISMATCH, 0, 0);
      end
      mode = MODE_RUN;
    end
    if (mode == MODE_WAIT) return mk(K_NEED, 0, pc_now);
    if (mode == MODE_HALT) return mk(K_HALT, 0, pc_now);
    forever begin
      p = pc_now;
      if (p >= prog_len) begin
        mode = MODE_HALT;
        return mk(K_HALT, 0, p);
      end
      if (steps >= limit_now) return mk(K_LIMIT, 0, p);
      steps++;
      pc_now = p + 1;
      case (prog_mem[p])
        C_RIGHT: begin
          if (ptr + 1 >= TapeDepth) begin
            pc_now = p;
            mode = MODE_HALT;
            return mk(K_OVER, 0, p);
          end
          ptr++;
        end
        C_LEFT: begin
          if (ptr == 0) begin
            pc_now = p;
            mode = MODE_HALT;
            return mk(K_UNDER, 0, p);
          end
          ptr--;
        end
        C_INC: cells[ptr] = cells[ptr] + 8'd1;
        C_DEC: cells[ptr] = cells[ptr] - 8'd1;
        C_OUT: return mk(K_OUT, cells[ptr], p);
        C_IN: begin
          mode = MODE_WAIT;
          return mk(K_NEED, 0, p);
        end
        C_OPEN:  if (cells[ptr] == 8'd0) pc_now = jump_to[p] + 1;
        default: if (cells[ptr] != 8'd0) pc_now = jump_to[p] + 1;
      endcase
    end
  endfunction

  // Expected result of one accepted beat; updates the predictor state
  function automatic result_t predict_machine(op_t op, logic [7:0] ch);
    cmd_t c;
    bit   known;
    int   at;
    int   o;
    known = 1'b1;
    at = prog_len;
    c = C_RIGHT;
    case (op)
      OP_LOAD: begin
        case (ch)
          ">": c = C_RIGHT;
          "<": c = C_LEFT;
          "+": c = C_INC;
          "-": c = C_DEC;
          ".": c = C_OUT;
          ",": c = C_IN;
          "[": c = C_OPEN;
          "]": c = C_CLOSE;
          default: known = 1'b0;
        endcase
        if (mode != MODE_LOAD || !known) return mk(K_IGNORE, 0, at);
        if (at >= ProgDepth) return mk(K_FULL, 0, at);
        if (c == C_OPEN) begin
          if (depth >= NestDepth) begin
            mode = MODE_HALT;
            return mk(K_MISMATCH, 0, at);
          end
          open_stk[depth] = at;
          depth++;
        end else if (c == C_CLOSE) begin
          if (depth == 0) begin
            mode = MODE_HALT;
            return mk(K_MISMATCH, 0, at);
          end
          depth--;
          o = open_stk[depth];
          jump_to[at] = o;
          jump_to[o] = at;
        end
        prog_mem[at] = c;
        prog_len = at + 1;
        return mk(K_ACCEPT, 0, at);
      end
      OP_RUN: return execute_run();
      OP_FEED: begin
        if (mode != MODE_WAIT) return mk(K_IGNORE, 0, pc_now);
        cells[ptr] = ch;
        mode = MODE_RUN;
        return mk(K_ACCEPT, 0, pc_now);
      end
      default: begin
        wipe_machine();
        return mk(K_ACCEPT, 0, 0);
      end
    endcase
  endfunction

  // One input beat; typed expectation overrides the prediction when given
  task automatic send_beat(op_t op, logic [7:0] pl, bit typed = 0,
                           result_t want = '0);
    result_t r;
    int gap;
    in_op = op;
    in_payload = pl;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_machine(op, pl);
    if (typed) r = want;
    pending_q.insert(pending_q.size(), r);
    beats_done++;
    @(negedge clk);
    start = 1'b0;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Step limit write, only with the machine idle
  task automatic write_limit(logic [15:0] v);
    drain_results();
    cfg_step_limit = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_now = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] pick_cmd();
    string cmds;
    cmds = "><+-.,";
    return cmds[$urandom_range(0, 5)];
  endfunction

  // Random program, mostly balanced brackets, then run/feed beats
  task automatic program_session();
    int n;
    int open_cnt;
    int r;
    int beats;
    bit broken;
    no_idle = ($urandom_range(0, 9) < 3);
    send_beat(OP_CLEAR, 8'($urandom()));
    n = $urandom_range(1, 30);
    open_cnt = 0;
    broken = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_beat(OP_LOAD, 8'($urandom()));
      else if (r < 22 && open_cnt < 6) begin
        send_beat(OP_LOAD, "[");
        open_cnt++;
      end else if (r < 36 && (open_cnt > 0 || broken)) begin
        send_beat(OP_LOAD, "]");
        if (open_cnt > 0) open_cnt--;
      end else send_beat(OP_LOAD, pick_cmd());
    end
    if (!broken) begin
      while (open_cnt > 0) begin
        send_beat(OP_LOAD, "]");
        open_cnt--;
      end
    end
    beats = $urandom_range(2, 25);
    for (int i = 0; i < beats; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_beat(op_t'($urandom_range(0, 2)), 8'($urandom()));
      else if (mode == MODE_WAIT && r < 85) send_beat(OP_FEED, 8'($urandom()));
      else send_beat(OP_RUN, 8'($urandom()));
      if (mode == MODE_HALT && $urandom_range(0, 1)) break;
    end
  endtask

  // Fill the program with moves right: program full, then overflow at the end
  task automatic tape_end_session();
    no_idle = 1'b1;
    send_beat(OP_CLEAR, 8'd0);
    for (int i = 0; i < ProgDepth; i++) send_beat(OP_LOAD, ">");
    send_beat(OP_LOAD, "+", 1, mk(K_FULL, 0, ProgDepth));
    send_beat(OP_RUN, 8'd0, 1, mk(K_OVER, 0, ProgDepth - 1));
    send_beat(OP_RUN, 8'd0, 1, mk(K_HALT, 0, ProgDepth - 1));
  endtask

  // Nesting one level too deep
  task automatic deep_nest_session();
    no_idle = 1'b0;
    send_beat(OP_CLEAR, 8'd0);
    for (int i = 0; i < NestDepth; i++) send_beat(OP_LOAD, "[");
    send_beat(OP_LOAD, "[", 1, mk(K_MISMATCH, 0, NestDepth));
    send_beat(OP_RUN, 8'd0, 1, mk(K_HALT, 0, 0));
  endtask

  // Result checker: every strobe beat against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_strobe) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind %0d byte %0h pc %0d",
                   out_kind, out_out_byte, out_at_pc);
      end else begin
        want = pending_q.pop_front();
        if (out_kind !== want.kind || out_out_byte !== want.value ||
            out_at_pc !== want.pc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d byte %0h pc %0d, got %0d %0h %0d",
                     want.kind, want.value, want.pc,
                     out_kind, out_out_byte, out_at_pc);
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("status: fail");
      $finish;
    end
  end

  row_t dir_rows[$];

  task automatic add_row(op_t op, logic [7:0] pl, bit typed = 0,
                         logic [3:0] k = 0, logic [7:0] v = 0, int p = 0);
    row_t rw;
    rw.op = op;
    rw.payload = pl;
    rw.typed = typed;
    rw.res = mk(k, v, p);
    dir_rows.insert(dir_rows.size(), rw);
  endtask

  initial begin
    int phase;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_LOAD;
    in_payload = 8'd0;
    cfg_valid = 1'b0;
    cfg_step_limit = 16'hFFFF;
    beats_done = 0;
    mismatches = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    limit_now = 65535;
    wipe_machine();

    // Directed table: after reset, error kinds, input/output, a wrapping loop
    add_row(OP_RUN,   8'h00, 1, K_HALT, 0, 0);
    add_row(OP_LOAD,  "+",   1, K_IGNORE, 0, 0);
    add_row(OP_FEED,  8'hFF, 1, K_IGNORE, 0, 0);
    add_row(OP_CLEAR, 8'hFF, 1, K_ACCEPT, 0, 0);
    add_row(OP_LOAD,  "a",   1, K_IGNORE, 0, 0);
    add_row(OP_LOAD,  "]",   1, K_MISMATCH, 0, 0);
    add_row(OP_CLEAR, 8'h00, 1, K_ACCEPT, 0, 0);
    add_row(OP_LOAD,  ",",   1, K_ACCEPT, 0, 0);
    add_row(OP_LOAD,  ".",   1, K_ACCEPT, 0, 1);
    add_row(OP_LOAD,  "<",   1, K_ACCEPT, 0, 2);
    add_row(OP_RUN,   8'h00, 1, K_NEED, 0, 0);
    add_row(OP_RUN,   8'h00, 1, K_NEED, 0, 1);
    add_row(OP_FEED,  8'hFF, 1, K_ACCEPT, 0, 1);
    add_row(OP_FEED,  8'h00, 1, K_IGNORE, 0, 1);
    add_row(OP_RUN,   8'h00, 1, K_OUT, 8'hFF, 1);
    add_row(OP_RUN,   8'h00, 1, K_UNDER, 0, 2);
    add_row(OP_CLEAR, 8'h00, 1, K_ACCEPT, 0, 0);
    add_row(OP_LOAD,  "[");
    add_row(OP_RUN,   8'h00, 1, K_MISMATCH, 0, 0);
    add_row(OP_CLEAR, 8'h00);
    add_row(OP_LOAD,  "-");
    add_row(OP_LOAD,  "[");
    add_row(OP_LOAD,  "-");
    add_row(OP_LOAD,  "]");
    add_row(OP_LOAD,  ">");
    add_row(OP_LOAD,  "+");
    add_row(OP_RUN,   8'h00);

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].payload, dir_rows[i].typed,
                dir_rows[i].res);

    // Random phases, each under its own step limit; extremes first
    phase = 0;
    while (beats_done < TargetBeats) begin
      case (phase)
        0:       write_limit(16'd0);
        1:       write_limit(16'd1);
        2:       write_limit(16'hFFFF);
        default: write_limit(($urandom_range(0, 9) == 0) ?
                             16'($urandom_range(300, 1500)) :
                             16'($urandom_range(2, 150)));
      endcase
      if (phase == 2) tape_end_session();
      else begin
        if (phase == 1) deep_nest_session();
        repeat (6) begin
          if ($urandom_range(0, 7) == 0) drain_results();
          program_session();
        end
      end
      phase++;
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
